### rtl/saa_pkg.sv
// Types and constants shared by the skyline atlas allocator modules.
// No dependencies; every other file in rtl imports this package.
`timescale 1ns / 1ps
`default_nettype none

package saa_pkg;

  localparam int EXT_W  = 14;  // texel extent field width
  localparam int SIZE_W = 11;  // rectangle width/height in columns/rows, up to 1024
  localparam int POS_W  = 10;  // pos_x / pos_y field width
  localparam int ATL_W  = 2;   // atlas_index field width

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  typedef enum logic [2:0] {
    ST_PLACED    = 3'd0,
    ST_SKIPPED   = 3'd1,
    ST_BEGIN     = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FATAL     = 3'd4
  } status_t;

  typedef struct packed {
    logic             opcode;
    logic             skip_surface;
    logic [EXT_W-1:0] extent_s;
    logic [EXT_W-1:0] extent_t;
  } in_item_t;

  typedef struct packed {
    status_t          status;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic [ATL_W-1:0] atlas_index;
  } out_item_t;

  // Request from the allocator control to the window scan unit.
  typedef struct packed {
    logic              start;
    logic [SIZE_W-1:0] size_w;
  } scan_req_t;

  typedef enum logic [2:0] {
    T_CLEAR,
    T_IDLE,
    T_SCAN,
    T_FILL,
    T_RESP
  } top_state_t;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_SUFFIX,
    SC_PREFIX
  } scan_phase_t;

endpackage

`default_nettype wire

### rtl/saa_scan.sv
// Window scan unit: finds the start column whose highest column under a span of
// size_w is lowest. Holds the block-suffix memory; uses saa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module saa_scan #(
  parameter int ATLAS_WIDTH  = 1024,
  parameter int ATLAS_HEIGHT = 1024,
  localparam int XW = $clog2(ATLAS_WIDTH),
  localparam int HW = $clog2(ATLAS_HEIGHT + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  saa_pkg::scan_req_t req,
  output logic [XW-1:0]     rd_addr,
  input  logic [HW-1:0]     rd_data,
  output logic              done,
  output logic [HW-1:0]     best,
  output logic [XW-1:0]     best_x
);
  import saa_pkg::*;

  localparam logic [XW-1:0] XLAST = XW'(ATLAS_WIDTH - 1);
  localparam logic [XW-1:0] XSTOP = XW'(ATLAS_WIDTH - 2);

  typedef struct packed {
    logic          blk_start;
    logic [HW-1:0] val;
  } sfx_t;

  sfx_t sfx_mem [ATLAS_WIDTH];
  sfx_t sa_q;
  sfx_t sb_q;

  scan_phase_t phase;
  scan_phase_t phase_next;

  logic [XW-1:0] j;
  logic [XW-1:0] c;
  logic [XW-1:0] wm1;
  logic [XW-1:0] d_j;
  logic [XW-1:0] s_addr;
  logic          iss;
  logic          iss_last;
  logic          d_vld;
  logic          d_last;
  logic          fin;
  logic [HW-1:0] suf;
  logic [HW-1:0] pre;
  logic [HW-1:0] suf_new;
  logic [HW-1:0] pre_new;
  logic [HW-1:0] win_max;
  logic          eval;

  // The suffix pass runs right to left in blocks of size_w columns counted
  // from the right edge; the prefix pass runs left to right. A window crosses
  // at most one block edge, so its maximum is max(suffix at start, prefix at end).
  assign rd_addr  = j;
  assign s_addr   = j - wm1;
  assign iss_last = iss && (((phase == SC_SUFFIX) && (j == '0)) ||
                            ((phase == SC_PREFIX) && (j == XSTOP)));
  assign suf_new  = ((c == '0) || (rd_data > suf)) ? rd_data : suf;
  assign pre_new  = (sb_q.blk_start || (rd_data > pre)) ? rd_data : pre;
  assign win_max  = (sa_q.val > pre_new) ? sa_q.val : pre_new;
  assign eval     = (d_j >= wm1);

  always_comb begin
    phase_next = phase;
    fin        = 1'b0;
    case (phase)
      SC_IDLE: begin
        if (req.start) begin
          phase_next = SC_SUFFIX;
        end
      end
      SC_SUFFIX: begin
        if (d_vld && d_last) begin
          phase_next = SC_PREFIX;
        end
      end
      SC_PREFIX: begin
        if (d_vld && d_last) begin
          phase_next = SC_IDLE;
          fin        = 1'b1;
        end
      end
      default: phase_next = SC_IDLE;
    endcase
  end

  // Done is registered and rises in the cycle after the last window, once best holds its final value.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= SC_IDLE;
      done  <= 1'b0;
    end else begin
      phase <= phase_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss   <= 1'b0;
      d_vld <= 1'b0;
    end else begin
      d_vld <= iss;
      if ((phase == SC_IDLE) && req.start) begin
        iss <= 1'b1;
      end else if ((phase == SC_SUFFIX) && d_vld && d_last) begin
        iss <= 1'b1;
      end else if (iss_last) begin
        iss <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    d_j    <= j;
    d_last <= iss_last;
    case (phase)
      SC_IDLE: begin
        if (req.start) begin
          j      <= XLAST;
          c      <= '0;
          wm1    <= XW'(req.size_w - SIZE_W'(1));
          best   <= HW'(ATLAS_HEIGHT);
          best_x <= '0;
        end
      end
      SC_SUFFIX: begin
        if (d_vld && d_last) begin
          j <= '0;
        end else if (iss) begin
          j <= j - XW'(1);
        end
        if (d_vld) begin
          c   <= (c == wm1) ? '0 : c + XW'(1);
          suf <= suf_new;
        end
      end
      SC_PREFIX: begin
        if (iss) begin
          j <= j + XW'(1);
        end
        if (d_vld) begin
          pre <= pre_new;
          // Strict compare keeps the earliest start on a tie.
          if (eval && (win_max < best)) begin
            best   <= win_max;
            best_x <= d_j - wm1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if ((phase == SC_SUFFIX) && d_vld) begin
      sfx_mem[d_j] <= '{blk_start: (c == wm1) || (d_j == '0), val: suf_new};
    end
    sa_q <= sfx_mem[s_addr];
    sb_q <= sfx_mem[j];
  end

endmodule

`default_nettype wire

### rtl/skyline_atlas_allocator.sv
// Skyline atlas allocator top level: control, column height memory, result register.
// Depends on saa_pkg and saa_scan.
`timescale 1ns / 1ps
`default_nettype none

// Each beat on req is one command and yields exactly one beat on rsp. Commands
// are taken one at a time; the column heights live in a synchronous memory with
// one write port and one read port. A begin command clears that memory, one
// column per cycle. A skipped surface goes straight to its result. An allocation
// makes two passes over the height memory (block suffix maxima right to left,
// then prefix maxima and the window choice left to right), then writes back w
// columns, one per cycle. When the rectangle does not fit and a further atlas is
// available, a clear pass follows, and the retry on the empty atlas is decided
// without a scan. A rectangle as wide as the atlas skips the scan. A result beat
// that is still stalled holds the block in its response state until it leaves.
// After reset the block runs the same clear pass before it takes the first
// command.
module skyline_atlas_allocator #(
  parameter int ATLAS_WIDTH  = 1024,
  parameter int ATLAS_HEIGHT = 1024,
  parameter int MAX_ATLASES  = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  saa_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output saa_pkg::out_item_t rsp
);
  import saa_pkg::*;

  localparam int XW   = $clog2(ATLAS_WIDTH);
  localparam int HW   = $clog2(ATLAS_HEIGHT + 1);
  localparam int AW   = $clog2(MAX_ATLASES);
  localparam int SUMW = ((HW > SIZE_W) ? HW : SIZE_W) + 1;
  localparam logic [XW-1:0] XLAST = XW'(ATLAS_WIDTH - 1);

  top_state_t state;
  top_state_t state_next;
  top_state_t clr_target;

  logic [XW-1:0]     cidx;
  logic [AW-1:0]     cur_atlas;
  logic [AW:0]       atl_inc;
  logic [SIZE_W-1:0] w_q;
  logic [SIZE_W-1:0] h_q;
  logic [SIZE_W-1:0] w_in;
  logic [SIZE_W-1:0] h_in;
  logic [SIZE_W-1:0] fw;
  logic [SIZE_W-1:0] fh;
  logic [XW-1:0]     faddr;
  logic [SIZE_W-1:0] fcnt;
  logic [HW-1:0]     fill_val;
  status_t           pend_status;
  logic [XW-1:0]     pend_x;
  logic [HW-1:0]     pend_y;

  logic acc;
  logic wide_in;
  logic exhausted;
  logic fresh_fit;
  logic fail_now;
  logic scan_fit;
  logic rsp_load;
  logic [SUMW-1:0] top_sum;

  logic [XW+POS_W-1:0] px_wide;
  logic [HW+POS_W-1:0] py_wide;
  logic [AW+ATL_W-1:0] atl_wide;

  logic [HW-1:0] hmem [ATLAS_WIDTH];
  logic [HW-1:0] hq;
  logic          hw_en;
  logic [XW-1:0] hw_addr;
  logic [HW-1:0] hw_data;

  scan_req_t     scan_req;
  logic [XW-1:0] scan_addr;
  logic          scan_done;
  logic [HW-1:0] scan_best;
  logic [XW-1:0] scan_x;

  saa_scan #(
    .ATLAS_WIDTH (ATLAS_WIDTH),
    .ATLAS_HEIGHT(ATLAS_HEIGHT)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .req    (scan_req),
    .rd_addr(scan_addr),
    .rd_data(hq),
    .done   (scan_done),
    .best   (scan_best),
    .best_x (scan_x)
  );

  assign req_stall = (state != T_IDLE);
  assign acc       = req_valid && (state == T_IDLE);
  assign w_in      = SIZE_W'(req.extent_s >> 4) + SIZE_W'(1);
  assign h_in      = SIZE_W'(req.extent_t >> 4) + SIZE_W'(1);
  assign wide_in   = (w_in >= ATLAS_WIDTH);

  // Sizes for the fail path come straight from the beat when a too-wide
  // rectangle is rejected at accept time, and from the held copy after a scan.
  assign fw        = (state == T_IDLE) ? w_in : w_q;
  assign fh        = (state == T_IDLE) ? h_in : h_q;
  assign atl_inc   = (AW+1)'(cur_atlas) + (AW+1)'(1);
  assign exhausted = (atl_inc >= (AW+1)'(MAX_ATLASES));
  assign fresh_fit = (fw < ATLAS_WIDTH) && (fh <= ATLAS_HEIGHT);

  assign top_sum   = SUMW'(scan_best) + SUMW'(h_q);
  assign scan_fit  = (top_sum <= SUMW'(ATLAS_HEIGHT));

  assign scan_req.start  = acc && (req.opcode == OP_ALLOC) && !req.skip_surface && !wide_in;
  assign scan_req.size_w = w_in;

  assign fail_now = (acc && (req.opcode == OP_ALLOC) && !req.skip_surface && wide_in) ||
                    ((state == T_SCAN) && scan_done && !scan_fit);
  assign rsp_load = (state == T_RESP) && (!rsp_valid || !rsp_stall);

  assign px_wide  = (XW+POS_W)'(pend_x);
  assign py_wide  = (HW+POS_W)'(pend_y);
  assign atl_wide = (AW+ATL_W)'(cur_atlas);

  always_comb begin
    state_next = state;
    case (state)
      T_CLEAR: begin
        if (cidx == XLAST) begin
          state_next = clr_target;
        end
      end
      T_IDLE: begin
        if (acc) begin
          if (req.opcode == OP_BEGIN) begin
            state_next = T_CLEAR;
          end else if (req.skip_surface) begin
            state_next = T_RESP;
          end else if (wide_in) begin
            state_next = exhausted ? T_RESP : T_CLEAR;
          end else begin
            state_next = T_SCAN;
          end
        end
      end
      T_SCAN: begin
        if (scan_done) begin
          if (scan_fit) begin
            state_next = T_FILL;
          end else begin
            state_next = exhausted ? T_RESP : T_CLEAR;
          end
        end
      end
      T_FILL: begin
        if (fcnt == SIZE_W'(1)) begin
          state_next = T_RESP;
        end
      end
      T_RESP: begin
        if (rsp_load) begin
          state_next = T_IDLE;
        end
      end
      default: state_next = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= T_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_target <= T_IDLE;
      cidx       <= '0;
      cur_atlas  <= AW'(1);
      rsp_valid  <= 1'b0;
    end else begin
      if (state == T_CLEAR) begin
        cidx <= (cidx == XLAST) ? '0 : cidx + XW'(1);
      end
      if (acc && (req.opcode == OP_BEGIN)) begin
        cur_atlas  <= AW'(1);
        clr_target <= T_RESP;
      end
      if (fail_now && !exhausted) begin
        cur_atlas  <= atl_inc[AW-1:0];
        clr_target <= fresh_fit ? T_FILL : T_RESP;
      end
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Working registers and the result beat.
  always_ff @(posedge clk) begin
    if (acc) begin
      w_q <= w_in;
      h_q <= h_in;
    end
    if ((state == T_SCAN) && scan_done && scan_fit) begin
      faddr       <= scan_x;
      fcnt        <= w_q;
      fill_val    <= top_sum[HW-1:0];
      pend_status <= ST_PLACED;
      pend_x      <= scan_x;
      pend_y      <= scan_best;
    end
    if (fail_now) begin
      pend_x <= '0;
      pend_y <= '0;
      if (exhausted) begin
        pend_status <= ST_EXHAUSTED;
      end else if (fresh_fit) begin
        // An empty atlas always takes the rectangle at the origin.
        faddr       <= '0;
        fcnt        <= fw;
        fill_val    <= HW'(fh);
        pend_status <= ST_PLACED;
      end else begin
        pend_status <= ST_FATAL;
      end
    end else if (acc) begin
      pend_x      <= '0;
      pend_y      <= '0;
      pend_status <= (req.opcode == OP_BEGIN) ? ST_BEGIN : ST_SKIPPED;
    end
    if (state == T_FILL) begin
      faddr <= faddr + XW'(1);
      fcnt  <= fcnt - SIZE_W'(1);
    end
    if (rsp_load) begin
      rsp.status      <= pend_status;
      rsp.pos_x       <= px_wide[POS_W-1:0];
      rsp.pos_y       <= py_wide[POS_W-1:0];
      rsp.atlas_index <= atl_wide[ATL_W-1:0];
    end
  end

  assign hw_en   = (state == T_CLEAR) || (state == T_FILL);
  assign hw_addr = (state == T_FILL) ? faddr : cidx;
  assign hw_data = (state == T_FILL) ? fill_val : '0;

  always_ff @(posedge clk) begin
    if (hw_en) begin
      hmem[hw_addr] <= hw_data;
    end
    hq <= hmem[scan_addr];
  end

endmodule

`default_nettype wire

### bench/skyline_atlas_allocator_tb.sv
// Self-checking testbench for skyline_atlas_allocator: directed and random command beats,
// with a skyline tracker class that predicts every result beat and checks it.
// Depends on saa_pkg and the RTL of skyline_atlas_allocator.
`timescale 1ns / 1ps

module skyline_atlas_allocator_tb;
  import saa_pkg::*;

  localparam int ATLAS_W = 1024;
  localparam int ATLAS_H = 1024;
  localparam int MAX_ATL = 4;
  localparam int PHASE_COMMANDS = 68;
  localparam int DRAIN_CYCLES = 4200;
  localparam longint CYCLE_LIMIT = 5_000_000;

  // Mirrors the atlas skyline and the current atlas number, and keeps the result
  // beats that are still owed by the block.
  class skyline_tracker;
    localparam int COLS = ATLAS_W;
    localparam int ROWS = ATLAS_H;
    localparam int ATLASES = MAX_ATL;

    int unsigned col_top[COLS];
    int unsigned atlas_now;
    out_item_t   owed_results[$];
    int          mismatch_count;

    function new();
      clear_columns();
      atlas_now = 1;
      mismatch_count = 0;
    endfunction

    function void clear_columns();
      foreach (col_top[i]) col_top[i] = 0;
    endfunction

    // Lowest window wins, earliest start on a tie; the last start column is never tried.
    function bit fit_rect(int unsigned w, int unsigned h, output int unsigned px,
                          output int unsigned py);
      int unsigned best;
      int unsigned bx;
      int unsigned top;
      bit          usable;
      best = ROWS;
      bx = 0;
      px = 0;
      py = 0;
      if (w < COLS) begin
        for (int unsigned s = 0; s < COLS - w; s++) begin
          top = 0;
          usable = 1'b1;
          for (int unsigned k = 0; k < w; k++) begin
            if (col_top[s + k] >= best) begin
              usable = 1'b0;
              break;
            end
            if (col_top[s + k] > top) top = col_top[s + k];
          end
          if (usable) begin
            best = top;
            bx = s;
          end
        end
      end
      if (best + h > ROWS) return 1'b0;
      for (int unsigned k = 0; k < w; k++) col_top[bx + k] = best + h;
      px = bx;
      py = best;
      return 1'b1;
    endfunction

    function void note_command(in_item_t c);
      out_item_t   e;
      status_t     st;
      int unsigned px;
      int unsigned py;
      int unsigned w;
      int unsigned h;
      px = 0;
      py = 0;
      if (c.opcode == OP_BEGIN) begin
        clear_columns();
        atlas_now = 1;
        st = ST_BEGIN;
      end else if (c.skip_surface) begin
        st = ST_SKIPPED;
      end else begin
        w = (int'(c.extent_s) >> 4) + 1;
        h = (int'(c.extent_t) >> 4) + 1;
        if (fit_rect(w, h, px, py)) begin
          st = ST_PLACED;
        end else if (atlas_now + 1 >= ATLASES) begin
          st = ST_EXHAUSTED;
        end else begin
          atlas_now++;
          clear_columns();
          st = fit_rect(w, h, px, py) ? ST_PLACED : ST_FATAL;
        end
      end
      if (st != ST_PLACED) begin
        px = 0;
        py = 0;
      end
      e.status = st;
      e.pos_x = px[POS_W-1:0];
      e.pos_y = py[POS_W-1:0];
      e.atlas_index = atlas_now[ATL_W-1:0];
      owed_results = {owed_results, e};
    endfunction

    function void check_placement(out_item_t r);
      out_item_t e;
      if (owed_results.size() == 0) begin
        $error("result beat with nothing owed: status %0d x %0d y %0d atlas %0d",
               r.status, r.pos_x, r.pos_y, r.atlas_index);
        mismatch_count++;
        return;
      end
      e = owed_results.pop_front();
      if (r.status !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, r.status);
        mismatch_count++;
      end
      if (r.pos_x !== e.pos_x) begin
        $error("pos_x: expected %0d, got %0d", e.pos_x, r.pos_x);
        mismatch_count++;
      end
      if (r.pos_y !== e.pos_y) begin
        $error("pos_y: expected %0d, got %0d", e.pos_y, r.pos_y);
        mismatch_count++;
      end
      if (r.atlas_index !== e.atlas_index) begin
        $error("atlas_index: expected %0d, got %0d", e.atlas_index, r.atlas_index);
        mismatch_count++;
      end
    endfunction

    function int pending_count();
      return owed_results.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  in_item_t  req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  out_item_t rsp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  longint      cycle_count = 0;

  skyline_tracker tracker = new();

  skyline_atlas_allocator #(
    .ATLAS_WIDTH (ATLAS_W),
    .ATLAS_HEIGHT(ATLAS_H),
    .MAX_ATLASES (MAX_ATL)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) tracker.check_placement(rsp);
  end

  function automatic in_item_t cmd(logic op, logic skip, logic [EXT_W-1:0] es,
                                   logic [EXT_W-1:0] et);
    in_item_t c;
    c.opcode = op;
    c.skip_surface = skip;
    c.extent_s = es;
    c.extent_t = et;
    return c;
  endfunction

  // Mostly small rectangles, with enough large ones to fill atlases and run them out.
  function automatic logic [EXT_W-1:0] rand_extent();
    case ($urandom_range(9))
      0, 1, 2, 3, 4: return EXT_W'($urandom_range(255));
      5, 6, 7:       return EXT_W'($urandom_range(4095));
      default:       return EXT_W'($urandom_range(16383));
    endcase
  endfunction

  function automatic in_item_t random_command();
    logic op;
    op = ($urandom_range(99) < 4) ? OP_BEGIN : OP_ALLOC;
    return cmd(op, $urandom_range(9) == 0, rand_extent(), rand_extent());
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid stays high into the next call unless that call inserts a gap.
  task automatic send_item(input in_item_t item);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_command(item);
    @(negedge clk);
  endtask

  // Called at a falling edge; the sender goes idle until nothing is owed.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_item(cmd(OP_BEGIN, 1'b0, '0, '0));
    send_item(cmd(OP_BEGIN, 1'b1, '1, '1));
    send_item(cmd(OP_ALLOC, 1'b1, '1, '1));
    send_item(cmd(OP_ALLOC, 1'b0, '0, '0));
    // Full-width rectangle has no start column: fatal after moving to atlas 2.
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16383, 14'd0));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16352, 14'd0));
    // The free last column is never tried, so this one moves on to atlas 3.
    send_item(cmd(OP_ALLOC, 1'b0, 14'd0, 14'd16383));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd0, 14'd16383));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16383, 14'd0));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16383, 14'd16383));
    send_item(cmd(OP_ALLOC, 1'b1, 14'd0, 14'd0));
    send_item(cmd(OP_BEGIN, 1'b0, 14'd0, 14'd0));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd31, 14'd79));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd0, 14'd79));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd47, 14'd15));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16368, 14'd16368));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd16352, 14'd16383));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd0, 14'd0));
    send_item(cmd(OP_ALLOC, 1'b0, 14'd8191, 14'd8191));
    send_item(cmd(OP_ALLOC, 1'b0, 14'h2AAA, 14'h1555));
    send_item(cmd(OP_ALLOC, 1'b0, 14'h1555, 14'h2AAA));

    for (int phase = 0; phase < 4; phase++) begin
      // The sender holds off here until every owed result has arrived.
      wait_drained();
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 31;
          recv_stall_pct = 31;
        end
      endcase
      repeat (PHASE_COMMANDS) send_item(random_command());
    end
    req_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending_count() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### sim.f
rtl/saa_pkg.sv
rtl/saa_scan.sv
rtl/skyline_atlas_allocator.sv
bench/skyline_atlas_allocator_tb.sv
